### rtl/cuckoo_hash_insert_macros.svh
// ----------------------------------------------------------------------------
// cuckoo hash insert assertion macros
// overlapping-implication and next-cycle-implication checks on clk / rst
// ----------------------------------------------------------------------------
`ifndef CUCKOO_HASH_INSERT_MACROS_SVH
`define CUCKOO_HASH_INSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define CHI_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cuckoo_hash_insert: same-cycle check failed");

`define CHI_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cuckoo_hash_insert: next-cycle check failed");

`else

`define CHI_ASSERT_NOW(label, ante, cons)

`define CHI_ASSERT_NEXT(label, ante, cons)

`endif

`endif

### rtl/chi_pkg.sv
// ----------------------------------------------------------------------------
// chi_pkg
// shared types and codes of the two-table cuckoo hash insert block
// ----------------------------------------------------------------------------
package chi_pkg;

  localparam int KEY_W    = 31;
  localparam int STATUS_W = 2;
  localparam int KICKS_W  = 4;
  localparam int SLOT_W   = 4;

  // hash unit works on a zero-padded key, one digit of bits per cycle
  localparam int HASH_WORD_W  = 32;
  localparam int HASH_DIGIT_W = 8;
  localparam int HASH_STEPS   = HASH_WORD_W / HASH_DIGIT_W;

  typedef logic [KEY_W-1:0]    key_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [KICKS_W-1:0]  kicks_t;
  typedef logic [SLOT_W-1:0]   slot_t;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_READ   = 1'b1;

  localparam status_t STATUS_PLACED  = 2'd0;
  localparam status_t STATUS_DUP     = 2'd1;
  localparam status_t STATUS_DROPPED = 2'd2;
  localparam status_t STATUS_READ    = 2'd3;

endpackage

### rtl/cuckoo_hash_insert.sv
// ----------------------------------------------------------------------------
// cuckoo_hash_insert
// two-table cuckoo hash store with insert and slot read requests
// ----------------------------------------------------------------------------
// channel   ports                                  handshake
// request   opcode, key, table_sel, slot           start && !busy
// result    status, key_out, kicks                 done, one cycle, no stall
//
// an insert runs in rounds of the slot hash, one table read and one
// read-check-write step; one round per key placed, moved or found, at
// most MAX_KICKS rounds.
// a read raises done on leaving ST_READ, an insert of key zero in the
// cycle right after the accepting edge.
// after reset both tables are swept to zero with busy high.
// the next request may be taken while a result is on the ports.
// ----------------------------------------------------------------------------
module cuckoo_hash_insert #(
  parameter int TABLE_SIZE = 11,
  parameter int MAX_KICKS  = 10
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic              opcode,
  input  chi_pkg::key_t     key,
  input  logic              table_sel,
  input  chi_pkg::slot_t    slot,
  output logic              done,
  output chi_pkg::status_t  status,
  output chi_pkg::key_t     key_out,
  output chi_pkg::kicks_t   kicks
);

  import chi_pkg::*;

`include "cuckoo_hash_insert_macros.svh"

  localparam int ADDR_W = $clog2(TABLE_SIZE);
  localparam int KW     = $clog2(MAX_KICKS + 1);
  localparam int SX_W   = ADDR_W + SLOT_W;

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(TABLE_SIZE - 1);
  localparam logic [KW-1:0]     KICK_MAX  = KW'(MAX_KICKS);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_HASH  = 3'd2;
  localparam logic [2:0] ST_CHECK = 3'd3;
  localparam logic [2:0] ST_READ  = 3'd4;

  logic [2:0]        state;
  logic [ADDR_W-1:0] clr_addr;
  key_t              cur;
  logic              tbl;
  logic [KW-1:0]     kick_cnt;
  logic              rd_sel;
  logic              rd_ok;

  logic              hash_start;
  key_t              hash_key;
  logic              hash_done;
  logic [ADDR_W-1:0] pos_one;
  logic [ADDR_W-1:0] pos_two;

  logic              we_a;
  logic              we_b;
  logic [ADDR_W-1:0] waddr_a;
  logic [ADDR_W-1:0] waddr_b;
  key_t              wdata;
  logic              re;
  logic [ADDR_W-1:0] raddr_a;
  logic [ADDR_W-1:0] raddr_b;
  key_t              rd_a;
  key_t              rd_b;

  logic [SX_W-1:0]    slot_ext;
  logic               slot_ok;
  logic [ADDR_W-1:0]  slot_addr;
  logic               match;
  key_t               occ;
  logic [KW-1:0]      kick_cnt_next;
  logic [KW+KICKS_W-1:0] kick_ext;
  logic [KW+KICKS_W-1:0] kick_ext_next;
  logic [ADDR_W:0]    waddr_a_ext;
  logic [ADDR_W:0]    waddr_b_ext;

  assign busy          = (state != ST_IDLE);
  assign slot_ext      = {{ADDR_W{1'b0}}, slot};
  assign slot_ok       = (slot_ext < SX_W'(TABLE_SIZE));
  assign slot_addr     = slot_ext[ADDR_W-1:0];
  assign match         = (rd_a == cur) || (rd_b == cur);
  assign occ           = tbl ? rd_b : rd_a;
  assign kick_cnt_next = kick_cnt + 1'b1;
  assign kick_ext      = {{KICKS_W{1'b0}}, kick_cnt};
  assign kick_ext_next = {{KICKS_W{1'b0}}, kick_cnt_next};
  assign waddr_a_ext   = {1'b0, waddr_a};
  assign waddr_b_ext   = {1'b0, waddr_b};

  chi_hash #(
    .TABLE_SIZE(TABLE_SIZE)
  ) u_hash (
    .clk     (clk),
    .rst     (rst),
    .start   (hash_start),
    .key     (hash_key),
    .done    (hash_done),
    .pos_one (pos_one),
    .pos_two (pos_two)
  );

  chi_table #(
    .DEPTH(TABLE_SIZE)
  ) u_first (
    .clk   (clk),
    .we    (we_a),
    .waddr (waddr_a),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr_a),
    .rdata (rd_a)
  );

  chi_table #(
    .DEPTH(TABLE_SIZE)
  ) u_second (
    .clk   (clk),
    .we    (we_b),
    .waddr (waddr_b),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr_b),
    .rdata (rd_b)
  );

  // the write of a round lands before the next read, since the hash of the
  // evicted key sits in between; no forwarding needed
  always_comb begin
    we_a       = 1'b0;
    we_b       = 1'b0;
    waddr_a    = pos_one;
    waddr_b    = pos_two;
    wdata      = cur;
    re         = 1'b0;
    raddr_a    = pos_one;
    raddr_b    = pos_two;
    hash_start = 1'b0;
    hash_key   = key;
    case (state)
      ST_CLEAR: begin
        we_a    = 1'b1;
        we_b    = 1'b1;
        waddr_a = clr_addr;
        waddr_b = clr_addr;
        wdata   = '0;
      end
      ST_IDLE: begin
        if (start && opcode == OP_READ) begin
          re      = 1'b1;
          raddr_a = slot_addr;
          raddr_b = slot_addr;
        end else if (start && key != '0) begin
          hash_start = 1'b1;
        end
      end
      ST_HASH: begin
        re = hash_done;
      end
      ST_CHECK: begin
        if (!match) begin
          we_a = !tbl;
          we_b = tbl;
          if (occ != '0 && kick_cnt_next != KICK_MAX) begin
            hash_start = 1'b1;
            hash_key   = occ;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == LAST_ADDR) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (start) begin
            if (opcode == OP_READ) begin
              rd_sel <= table_sel;
              rd_ok  <= slot_ok;
              state  <= ST_READ;
            end else if (key == '0) begin
              // an empty slot already holds zero
              done    <= 1'b1;
              status  <= STATUS_DUP;
              key_out <= '0;
              kicks   <= '0;
            end else begin
              cur      <= key;
              tbl      <= 1'b0;
              kick_cnt <= '0;
              state    <= ST_HASH;
            end
          end
        end
        ST_HASH: begin
          if (hash_done) begin
            state <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (match) begin
            done    <= 1'b1;
            status  <= (kick_cnt == '0) ? STATUS_DUP : STATUS_PLACED;
            key_out <= '0;
            kicks   <= kick_ext[KICKS_W-1:0];
            state   <= ST_IDLE;
          end else if (occ == '0) begin
            done    <= 1'b1;
            status  <= STATUS_PLACED;
            key_out <= '0;
            kicks   <= kick_ext[KICKS_W-1:0];
            state   <= ST_IDLE;
          end else if (kick_cnt_next == KICK_MAX) begin
            // evicted key has nowhere left to go
            done    <= 1'b1;
            status  <= STATUS_DROPPED;
            key_out <= occ;
            kicks   <= kick_ext_next[KICKS_W-1:0];
            state   <= ST_IDLE;
          end else begin
            cur      <= occ;
            tbl      <= !tbl;
            kick_cnt <= kick_cnt_next;
            state    <= ST_HASH;
          end
        end
        ST_READ: begin
          done    <= 1'b1;
          status  <= STATUS_READ;
          key_out <= rd_ok ? (rd_sel ? rd_b : rd_a) : '0;
          kicks   <= '0;
          state   <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `CHI_ASSERT_NOW(a_hash_done_in_hash, hash_done, state == ST_HASH)
  `CHI_ASSERT_NOW(a_wr_a_in_range, we_a, waddr_a_ext < (ADDR_W + 1)'(TABLE_SIZE))
  `CHI_ASSERT_NOW(a_wr_b_in_range, we_b, waddr_b_ext < (ADDR_W + 1)'(TABLE_SIZE))
  `CHI_ASSERT_NEXT(a_insert_goes_busy, state == ST_IDLE && start && opcode == OP_INSERT && key != '0, busy && !done)

endmodule

### rtl/chi_hash.sv
// ----------------------------------------------------------------------------
// chi_hash
// multi-cycle slot hash: key mod size and (key div size) mod size
// ----------------------------------------------------------------------------
module chi_hash #(
  parameter int TABLE_SIZE = 11
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  chi_pkg::key_t                 key,
  output logic                          done,
  output logic [$clog2(TABLE_SIZE)-1:0] pos_one,
  output logic [$clog2(TABLE_SIZE)-1:0] pos_two
);

  import chi_pkg::*;

  localparam int ADDR_W = $clog2(TABLE_SIZE);
  localparam int CNT_W  = (HASH_STEPS > 1) ? $clog2(HASH_STEPS) : 1;
  localparam logic [ADDR_W:0]  DIV_CMP   = (ADDR_W + 1)'(TABLE_SIZE);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(HASH_STEPS - 1);

  logic [HASH_WORD_W-1:0] shreg;
  logic [ADDR_W-1:0]      rem_one;
  logic [ADDR_W-1:0]      rem_two;
  logic [CNT_W-1:0]       cnt;
  logic                   running;
  logic [ADDR_W-1:0]      rem_one_next;
  logic [ADDR_W-1:0]      rem_two_next;

  // long division by the table size, msb first; quotient bits feed a second
  // remainder chain so the quotient itself is never stored
  always_comb begin
    logic [ADDR_W:0] t1;
    logic [ADDR_W:0] t2;
    logic            qb;
    rem_one_next = rem_one;
    rem_two_next = rem_two;
    for (int i = 0; i < HASH_DIGIT_W; i++) begin
      t1 = {rem_one_next, shreg[HASH_WORD_W-1-i]};
      qb = (t1 >= DIV_CMP);
      if (qb) begin
        t1 = t1 - DIV_CMP;
      end
      rem_one_next = t1[ADDR_W-1:0];
      t2 = {rem_two_next, qb};
      if (t2 >= DIV_CMP) begin
        t2 = t2 - DIV_CMP;
      end
      rem_two_next = t2[ADDR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= '0;
        shreg   <= {{(HASH_WORD_W - KEY_W){1'b0}}, key};
        rem_one <= '0;
        rem_two <= '0;
      end else if (running) begin
        shreg   <= shreg << HASH_DIGIT_W;
        rem_one <= rem_one_next;
        rem_two <= rem_two_next;
        cnt     <= cnt + 1'b1;
        if (cnt == LAST_STEP) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  assign pos_one = rem_one;
  assign pos_two = rem_two;

endmodule

### rtl/chi_table.sv
// ----------------------------------------------------------------------------
// chi_table
// one hash table: single write port, registered read port
// ----------------------------------------------------------------------------
module chi_table #(
  parameter int DEPTH = 11
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  chi_pkg::key_t            wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output chi_pkg::key_t            rdata
);

  import chi_pkg::*;

  key_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: cuckoo_hash_insert testbench
// drives insert and read requests through the start/busy handshake, mirrors
// both hash tables in a local model and checks each done-strobed result in
// order, first with directed collision and edge cases, then random traffic
// ----------------------------------------------------------------------------
module tb_top;
  import chi_pkg::*;

  localparam int NUM_SLOTS    = 11;
  localparam int KICK_LIMIT   = 10;
  localparam int DRAIN_CYCLES = 6 * (KICK_LIMIT + 1) + 10;
  localparam int PHASE_ITEMS  = 200;

  typedef struct packed {
    status_t status;
    key_t    key_out;
    kicks_t  kicks;
  } hash_answer_t;

  // local copy of both tables, predicts the answer of every accepted request
  class table_mirror;
    key_t         t_one[NUM_SLOTS];
    key_t         t_two[NUM_SLOTS];
    hash_answer_t answers_due[$];
    int           n_errors;
    int           n_inserts;
    int           n_reads;
    int           n_dropped;
    int           n_moved;
    int           max_kicks;

    function new();
      foreach (t_one[i]) t_one[i] = '0;
      foreach (t_two[i]) t_two[i] = '0;
      n_errors  = 0;
      n_inserts = 0;
      n_reads   = 0;
      n_dropped = 0;
      n_moved   = 0;
      max_kicks = 0;
    endfunction

    function void apply_request(logic op, key_t k, logic sel, slot_t s);
      hash_answer_t ans;
      key_t         carry;
      key_t         occ;
      int           pos_a;
      int           pos_b;
      int           n;
      logic         in_two;
      logic         finished;
      ans = '0;
      if (op == OP_READ) begin
        n_reads++;
        ans.status = STATUS_READ;
        if (int'(s) < NUM_SLOTS) ans.key_out = sel ? t_two[s] : t_one[s];
      end else if (k == '0) begin
        n_inserts++;
        ans.status = STATUS_DUP;
      end else begin
        n_inserts++;
        carry    = k;
        in_two   = 1'b0;
        n        = 0;
        finished = 1'b0;
        while (!finished) begin
          if (n == KICK_LIMIT) begin
            ans.status  = STATUS_DROPPED;
            ans.key_out = carry;
            finished    = 1'b1;
          end else begin
            pos_a = int'(carry % NUM_SLOTS);
            pos_b = int'((carry / NUM_SLOTS) % NUM_SLOTS);
            if (t_one[pos_a] == carry || t_two[pos_b] == carry) begin
              // a find while carrying an evicted key still counts as placed
              ans.status = (n == 0) ? STATUS_DUP : STATUS_PLACED;
              finished   = 1'b1;
            end else begin
              if (in_two) begin
                occ          = t_two[pos_b];
                t_two[pos_b] = carry;
              end else begin
                occ          = t_one[pos_a];
                t_one[pos_a] = carry;
              end
              if (occ == '0) begin
                ans.status = STATUS_PLACED;
                finished   = 1'b1;
              end else begin
                carry  = occ;
                in_two = !in_two;
                n++;
              end
            end
          end
        end
        ans.kicks = kicks_t'(n);
        if (ans.status == STATUS_DROPPED) n_dropped++;
        if (n > 0) n_moved++;
        if (n > max_kicks) max_kicks = n;
      end
      answers_due.push_back(ans);
    endfunction

    function void compare_answer(status_t st, key_t ko, kicks_t kc);
      hash_answer_t exp_ans;
      if (answers_due.size() == 0) begin
        $error("result with no request pending: status %0d key_out %0h kicks %0d",
               st, ko, kc);
        n_errors++;
      end else begin
        exp_ans = answers_due.pop_front();
        if (st !== exp_ans.status) begin
          $error("status mismatch: expected %0d, got %0d", exp_ans.status, st);
          n_errors++;
        end
        if (ko !== exp_ans.key_out) begin
          $error("key_out mismatch: expected %0h, got %0h", exp_ans.key_out, ko);
          n_errors++;
        end
        if (kc !== exp_ans.kicks) begin
          $error("kicks mismatch: expected %0d, got %0d", exp_ans.kicks, kc);
          n_errors++;
        end
      end
    endfunction

    function int pending();
      return answers_due.size();
    endfunction
  endclass

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    start;
  logic    busy;
  logic    opcode;
  key_t    key;
  logic    table_sel;
  slot_t   slot;
  logic    done;
  status_t status;
  key_t    key_out;
  kicks_t  kicks;

  table_mirror mirror;
  key_t        used_keys[$];

  always #4 clk = ~clk;

  cuckoo_hash_insert #(
    .TABLE_SIZE(NUM_SLOTS),
    .MAX_KICKS (KICK_LIMIT)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .opcode   (opcode),
    .key      (key),
    .table_sel(table_sel),
    .slot     (slot),
    .done     (done),
    .status   (status),
    .key_out  (key_out),
    .kicks    (kicks)
  );

  always @(posedge clk) begin
    if (!rst && done === 1'b1) mirror.compare_answer(status, key_out, kicks);
  end

  // holds the request until taken; start stays high into the next request unless an idle gap is drawn
  task automatic issue_request(input logic op, input key_t k, input logic sel,
                               input slot_t s, input int idle_pct);
    int gap;
    gap = 0;
    while (gap < 8 && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start     <= 1'b1;
    opcode    <= op;
    key       <= k;
    table_sel <= sel;
    slot      <= s;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    mirror.apply_request(op, k, sel, s);
    if (op == OP_INSERT && k != '0) used_keys.push_back(k);
  endtask

  // keys on hash positions 0 to 3 in both tables, so chains and drops show up early
  function automatic key_t colliding_key();
    longint unsigned a;
    longint unsigned b;
    longint unsigned m;
    a = $urandom_range(3);
    b = $urandom_range(3);
    if ($urandom_range(3) == 0) m = $urandom_range(17_747_700);
    else m = $urandom_range(40);
    return key_t'(a + 11 * b + 121 * m + (a == 0 && b == 0 && m == 0));
  endfunction

  task automatic random_request(input int idle_pct);
    int   pick;
    logic op;
    key_t k;
    pick = $urandom_range(99);
    op   = OP_INSERT;
    k    = key_t'($urandom);
    if (pick < 20) op = OP_READ;
    else if (pick < 23) k = '0;
    else if (pick < 45 && used_keys.size() > 0)
      k = used_keys[$urandom_range(used_keys.size() - 1)];
    else if (pick < 75) k = colliding_key();
    else if (pick < 78) k = {KEY_W{1'b1}};
    issue_request(op, k, 1'($urandom_range(1)), slot_t'($urandom_range(15)), idle_pct);
  endtask

  initial begin
    #5_000_000;
    $display("FAIL cuckoo_hash_insert");
    $finish;
  end

  initial begin
    int guard;
    int idle_pct;
    mirror    = new();
    start     <= 1'b0;
    opcode    <= OP_INSERT;
    key       <= '0;
    table_sel <= 1'b0;
    slot      <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // empty tables, zero key, out of range reads, extreme keys
    issue_request(OP_READ,   '0,            1'b0, 4'd0,  0);
    issue_request(OP_READ,   '0,            1'b1, 4'd10, 0);
    issue_request(OP_READ,   {KEY_W{1'b1}}, 1'b1, 4'd15, 0);
    issue_request(OP_INSERT, '0,            1'b1, 4'd15, 0);
    issue_request(OP_INSERT, {KEY_W{1'b1}}, 1'b0, 4'd0,  0);
    issue_request(OP_INSERT, {KEY_W{1'b1}}, 1'b1, 4'd7,  0);
    issue_request(OP_INSERT, key_t'(1),     1'b0, 4'd0,  0);
    // same first-table slot: each new key pushes the occupant over, the repeat of 12 is a duplicate
    issue_request(OP_INSERT, key_t'(12),    1'b0, 4'd0,  0);
    issue_request(OP_INSERT, key_t'(23),    1'b0, 4'd0,  0);
    issue_request(OP_INSERT, key_t'(12),    1'b0, 4'd0,  0);
    // same slot in both tables: the third one runs into the kick limit
    issue_request(OP_INSERT, key_t'(38),    1'b0, 4'd0,  0);
    issue_request(OP_INSERT, key_t'(159),   1'b0, 4'd0,  0);
    issue_request(OP_INSERT, key_t'(280),   1'b0, 4'd0,  0);
    issue_request(OP_INSERT, key_t'(401),   1'b0, 4'd0,  0);
    issue_request(OP_READ,   '0,            1'b0, 4'd5,  0);
    issue_request(OP_READ,   '0,            1'b1, 4'd3,  0);
    issue_request(OP_READ,   '0,            1'b0, 4'd1,  0);
    issue_request(OP_READ,   '0,            1'b1, 4'd1,  0);
    issue_request(OP_READ,   '0,            1'b1, 4'd11, 0);
    issue_request(OP_INSERT, key_t'(31'h5555_5555), 1'b1, 4'd5, 0);
    issue_request(OP_INSERT, key_t'(31'h2AAA_AAAA), 1'b0, 4'd10, 0);
    issue_request(OP_READ,   key_t'(31'h2AAA_AAAA), 1'b0, 4'd12, 0);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        1:       idle_pct = 64;
        3:       idle_pct = 15;
        default: idle_pct = 0;
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) random_request(idle_pct);
    end
    start <= 1'b0;

    guard = 0;
    while (mirror.pending() != 0 && guard < 4000) begin
      @(posedge clk);
      guard++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mirror.pending() != 0) begin
      $error("%0d results never arrived", mirror.pending());
      mirror.n_errors++;
    end

    $display("covered %0d inserts and %0d slot reads", mirror.n_inserts, mirror.n_reads);
    $display("%0d inserts moved keys, %0d hit the kick limit, longest chain %0d",
             mirror.n_moved, mirror.n_dropped, mirror.max_kicks);
    if (mirror.n_errors == 0) begin
      $display("PASS cuckoo_hash_insert");
    end else begin
      $display("FAIL cuckoo_hash_insert");
    end
    $finish;
  end

endmodule

### cuckoo_hash_insert.f
+incdir+rtl
rtl/chi_pkg.sv
rtl/chi_hash.sv
rtl/chi_table.sv
rtl/cuckoo_hash_insert.sv
tb/tb_top.sv
